// ===== rtl/frequency_to_note_converter_macros.svh =====
// ----------------------------------------------------------------------------
// Frequency to note converter assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_TO_NOTE_CONVERTER_MACROS_SVH
`define FREQUENCY_TO_NOTE_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define F2N_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frequency_to_note_converter assertion failed");
`define F2N_ASSERT_OUT(lbl, prop) `F2N_ASSERT(lbl, out_valid |-> (prop))
`else
`define F2N_ASSERT(lbl, prop)
`define F2N_ASSERT_OUT(lbl, prop)
`endif
`endif

// ===== rtl/f2n_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency to note converter package
// Status codes, per-stage control bundle and fixed constants.
// ----------------------------------------------------------------------------
package f2n_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FREQ_ZERO = 2'd1,
    STATUS_REF_ZERO  = 2'd2
  } status_t;

  // Control that travels alongside the payload through every stage.
  typedef struct packed {
    logic    valid;
    status_t status;
  } ctl_t;

  localparam int unsigned MANT_W = 31;
  localparam int unsigned EXP_W  = 5;
  localparam int unsigned NOTE_A4 = 69;
  localparam logic [23:0] REF_A4_RESET = 24'd112640;

endpackage

// ===== rtl/frequency_to_note_converter.sv =====
`timescale 1ns / 1ps
// The log carries LOG_FRAC_BITS fraction bits, 16 by default.
// Throughput: one transaction per cycle; busy is always low.
// The row of LOG_FRAC_BITS squaring cells sets the depth, one log bit each.
// Reset (rst_n low, synchronous) empties the pipeline and sets A4 to 440 Hz.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Frequency to note converter
// Converts a Q16.8 frequency to the nearest note number, its deviation in
// 1/16 cent, pitch class and octave, against a programmable A4 reference.
// ----------------------------------------------------------------------------
`include "frequency_to_note_converter_macros.svh"

module frequency_to_note_converter #(
  parameter int LOG_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [23:0]         in_frequency,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_wdata,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [9:0]   out_nearest_note,
  output logic signed [10:0]  out_cents_offset,
  output logic                out_has_pitch_class,
  output logic [3:0]          out_pitch_class,
  output logic signed [5:0]   out_octave
);
  import f2n_pkg::*;

  localparam int LW = LOG_FRAC_BITS + EXP_W;
  localparam int LATENCY = LOG_FRAC_BITS + 6;

  logic [23:0] ref_a4_r, ref_a4_nxt;

  ctl_t              chain_ctl   [LOG_FRAC_BITS+1];
  logic [MANT_W-1:0] chain_m_f   [LOG_FRAC_BITS+1];
  logic [MANT_W-1:0] chain_m_a   [LOG_FRAC_BITS+1];
  logic [LW-1:0]     chain_log_f [LOG_FRAC_BITS+1];
  logic [LW-1:0]     chain_log_a [LOG_FRAC_BITS+1];

  assign busy = 1'b0;
  assign ref_a4_nxt = cfg_we ? cfg_wdata : ref_a4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_a4_r <= REF_A4_RESET;
    end else begin
      ref_a4_r <= ref_a4_nxt;
    end
  end

  f2n_norm #(.LW(LW)) u_norm (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (start && !busy),
    .in_frequency (in_frequency),
    .in_reference (ref_a4_r),
    .out_ctl      (chain_ctl[0]),
    .out_m_f      (chain_m_f[0]),
    .out_m_a      (chain_m_a[0]),
    .out_log_f    (chain_log_f[0]),
    .out_log_a    (chain_log_a[0])
  );

  for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_cell
    f2n_cell #(.LW(LW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_ctl    (chain_ctl[k]),
      .in_m_f    (chain_m_f[k]),
      .in_m_a    (chain_m_a[k]),
      .in_log_f  (chain_log_f[k]),
      .in_log_a  (chain_log_a[k]),
      .out_ctl   (chain_ctl[k+1]),
      .out_m_f   (chain_m_f[k+1]),
      .out_m_a   (chain_m_a[k+1]),
      .out_log_f (chain_log_f[k+1]),
      .out_log_a (chain_log_a[k+1])
    );
  end

  f2n_post #(.FRAC(LOG_FRAC_BITS)) u_post (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ctl              (chain_ctl[LOG_FRAC_BITS]),
    .in_log_f            (chain_log_f[LOG_FRAC_BITS]),
    .in_log_a            (chain_log_a[LOG_FRAC_BITS]),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_nearest_note    (out_nearest_note),
    .out_cents_offset    (out_cents_offset),
    .out_has_pitch_class (out_has_pitch_class),
    .out_pitch_class     (out_pitch_class),
    .out_octave          (out_octave)
  );

  // Every accepted transaction leaves the pipeline after a fixed delay, and
  // nothing leaves that was not accepted.
  `F2N_ASSERT(a_latency, start |-> ##LATENCY out_valid)
  `F2N_ASSERT(a_no_spurious, out_valid |-> $past(start, LATENCY))
  `F2N_ASSERT_OUT(a_err_fields, out_status == STATUS_OK || (out_nearest_note == 10'sd0 && out_cents_offset == 11'sd0 && !out_has_pitch_class))
  `F2N_ASSERT_OUT(a_pitch_class, !out_has_pitch_class || (out_pitch_class < 4'd12 && !out_nearest_note[9]))
  `F2N_ASSERT_OUT(a_cents_range, out_cents_offset <= 11'sd800 && out_cents_offset >= -11'sd800)

endmodule

// ===== rtl/f2n_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand normalizer
// Finds the leading one of both operands, aligns each mantissa to
// [2^30, 2^31) and seeds the log accumulator with the integer part.
// ----------------------------------------------------------------------------
module f2n_norm #(
  parameter int LW = 21
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_take,
  input  logic [23:0]                         in_frequency,
  input  logic [23:0]                         in_reference,
  output f2n_pkg::ctl_t                       out_ctl,
  output logic [f2n_pkg::MANT_W-1:0]          out_m_f,
  output logic [f2n_pkg::MANT_W-1:0]          out_m_a,
  output logic [LW-1:0]                       out_log_f,
  output logic [LW-1:0]                       out_log_a
);
  import f2n_pkg::*;

  function automatic logic [EXP_W-1:0] msb_index(input logic [23:0] x);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) begin
        idx = EXP_W'(i);
      end
    end
    return idx;
  endfunction

  logic [EXP_W-1:0]  e_f, e_a;
  ctl_t              ctl_r, ctl_nxt;
  logic [MANT_W-1:0] m_f_r, m_f_nxt, m_a_r, m_a_nxt;
  logic [LW-1:0]     log_f_r, log_f_nxt, log_a_r, log_a_nxt;

  always_comb begin
    e_f = msb_index(in_frequency);
    e_a = msb_index(in_reference);
    // The shift of {x, 7'b0} by 23 - e places the leading one at bit 30.
    m_f_nxt = {in_frequency, 7'b0} << (EXP_W'(23) - e_f);
    m_a_nxt = {in_reference, 7'b0} << (EXP_W'(23) - e_a);
    log_f_nxt = LW'(e_f);
    log_a_nxt = LW'(e_a);
    ctl_nxt.valid = in_take;
    if (in_frequency == '0) begin
      ctl_nxt.status = STATUS_FREQ_ZERO;
    end else if (in_reference == '0) begin
      ctl_nxt.status = STATUS_REF_ZERO;
    end else begin
      ctl_nxt.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.status <= ctl_nxt.status;
    m_f_r        <= m_f_nxt;
    m_a_r        <= m_a_nxt;
    log_f_r      <= log_f_nxt;
    log_a_r      <= log_a_nxt;
  end

  assign out_ctl   = ctl_r;
  assign out_m_f   = m_f_r;
  assign out_m_a   = m_a_r;
  assign out_log_f = log_f_r;
  assign out_log_a = log_a_r;

endmodule

// ===== rtl/f2n_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squaring cell
// One fraction bit of log2 for both operands: square the mantissa, take
// the bit that overflows past 2, renormalize and shift it into the log.
// ----------------------------------------------------------------------------
module f2n_cell #(
  parameter int LW = 21
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  f2n_pkg::ctl_t                       in_ctl,
  input  logic [f2n_pkg::MANT_W-1:0]          in_m_f,
  input  logic [f2n_pkg::MANT_W-1:0]          in_m_a,
  input  logic [LW-1:0]                       in_log_f,
  input  logic [LW-1:0]                       in_log_a,
  output f2n_pkg::ctl_t                       out_ctl,
  output logic [f2n_pkg::MANT_W-1:0]          out_m_f,
  output logic [f2n_pkg::MANT_W-1:0]          out_m_a,
  output logic [LW-1:0]                       out_log_f,
  output logic [LW-1:0]                       out_log_a
);
  import f2n_pkg::*;

  logic [2*MANT_W-1:0] sq_f, sq_a;
  logic [MANT_W:0]     t_f, t_a;
  ctl_t                ctl_r;
  logic [MANT_W-1:0]   m_f_r, m_f_nxt, m_a_r, m_a_nxt;
  logic [LW-1:0]       log_f_r, log_f_nxt, log_a_r, log_a_nxt;

  assign sq_f = in_m_f * in_m_f;
  assign sq_a = in_m_a * in_m_a;

  always_comb begin
    t_f = sq_f[2*MANT_W-1:MANT_W-1];
    t_a = sq_a[2*MANT_W-1:MANT_W-1];
    m_f_nxt   = t_f[MANT_W] ? t_f[MANT_W:1] : t_f[MANT_W-1:0];
    m_a_nxt   = t_a[MANT_W] ? t_a[MANT_W:1] : t_a[MANT_W-1:0];
    log_f_nxt = {in_log_f[LW-2:0], t_f[MANT_W]};
    log_a_nxt = {in_log_a[LW-2:0], t_a[MANT_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= in_ctl.valid;
    end
    ctl_r.status <= in_ctl.status;
    m_f_r        <= m_f_nxt;
    m_a_r        <= m_a_nxt;
    log_f_r      <= log_f_nxt;
    log_a_r      <= log_a_nxt;
  end

  assign out_ctl   = ctl_r;
  assign out_m_f   = m_f_r;
  assign out_m_a   = m_a_r;
  assign out_log_f = log_f_r;
  assign out_log_a = log_a_r;

endmodule

// ===== rtl/f2n_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arithmetic pipeline
// Five stages: continuous note, nearest note, remainder, cents scaling with
// the divide by twelve, then rounding and the output register.
// ----------------------------------------------------------------------------
module f2n_post #(
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  f2n_pkg::ctl_t        in_ctl,
  input  logic [FRAC+4:0]      in_log_f,
  input  logic [FRAC+4:0]      in_log_a,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic signed [9:0]    out_nearest_note,
  output logic signed [10:0]   out_cents_offset,
  output logic                 out_has_pitch_class,
  output logic [3:0]           out_pitch_class,
  output logic signed [5:0]    out_octave
);
  import f2n_pkg::*;

  localparam int LW = FRAC + 5;
  localparam int NW = FRAC + 11;
  localparam int RW = FRAC + 1;
  localparam int CW = FRAC + 12;
  localparam logic signed [NW-1:0] A4_NOTE_FIX = NW'(NOTE_A4) << FRAC;
  localparam logic signed [NW-1:0] N_HALF = NW'(1) << (FRAC - 1);
  localparam logic signed [CW-1:0] C_HALF = CW'(1) << (FRAC - 1);
  // floor(q * 2731 / 2^15) equals q / 12 for every q below 512.
  localparam logic [20:0] RECIP12 = 21'd2731;

  ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;

  logic signed [LW:0]    diff;
  logic signed [NW-1:0]  dx, n1_nxt, n1_r, n2_r, qsum;
  logic signed [9:0]     q2_nxt, q2_r, q3_r, q4_r;
  logic signed [RW-1:0]  r3_nxt, r3_r;
  logic signed [CW-1:0]  ce, c4_nxt, c4_r, csum;
  logic [20:0]           prod;
  logic [5:0]            quot4_nxt, quot4_r;
  logic [8:0]            rem9;
  logic                  has;

  logic                  valid_r;
  logic [1:0]            status_r, status_nxt;
  logic signed [9:0]     note_r, note_nxt;
  logic signed [10:0]    cents_r, cents_nxt;
  logic                  has_r, has_nxt;
  logic [3:0]            pc_r, pc_nxt;
  logic signed [5:0]     oct_r, oct_nxt;

  function automatic logic signed [NW-1:0] n2_dummy_free(input logic signed [NW-1:0] n);
    return n + N_HALF - $signed(NW'(n[NW-1]));
  endfunction

  always_comb begin
    // Stage 1: n = 69*2^F + 12*(log2 f - log2 a4).
    diff   = $signed({1'b0, in_log_f}) - $signed({1'b0, in_log_a});
    dx     = NW'(diff);
    n1_nxt = (dx <<< 3) + (dx <<< 2) + A4_NOTE_FIX;

    // Stage 2: ties away from zero; a negative n loses one so that the
    // arithmetic shift rounds its magnitude the same way.
    qsum   = n2_dummy_free(n1_r);
    q2_nxt = 10'(qsum >>> FRAC);

    // Stage 3: remainder of n against the nearest note.
    r3_nxt = RW'(n2_r - (NW'(q2_r) <<< FRAC));

    // Stage 4: scale by 1600 and divide the note by twelve.
    ce        = CW'(r3_r);
    c4_nxt    = (ce <<< 10) + (ce <<< 9) + (ce <<< 6);
    prod      = 21'(q3_r[8:0]) * RECIP12;
    quot4_nxt = prod[20:15];

    // Stage 5: round the cents and form the pitch fields.
    csum      = c4_r + C_HALF - $signed(CW'(c4_r[CW-1]));
    rem9      = q4_r[8:0] - 9'({3'b0, quot4_r} * 9'd12);
    has       = !q4_r[9];
    status_nxt = ctl4_r.status;
    if (ctl4_r.status == STATUS_OK) begin
      note_nxt  = q4_r;
      cents_nxt = 11'(csum >>> FRAC);
      has_nxt   = has;
      pc_nxt    = has ? rem9[3:0] : 4'd0;
      oct_nxt   = has ? $signed(quot4_r - 6'd1) : 6'sd0;
    end else begin
      note_nxt  = '0;
      cents_nxt = '0;
      has_nxt   = 1'b0;
      pc_nxt    = '0;
      oct_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
      ctl3_r.valid <= 1'b0;
      ctl4_r.valid <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      ctl1_r.valid <= in_ctl.valid;
      ctl2_r.valid <= ctl1_r.valid;
      ctl3_r.valid <= ctl2_r.valid;
      ctl4_r.valid <= ctl3_r.valid;
      valid_r      <= ctl4_r.valid;
    end
    ctl1_r.status <= in_ctl.status;
    ctl2_r.status <= ctl1_r.status;
    ctl3_r.status <= ctl2_r.status;
    ctl4_r.status <= ctl3_r.status;
    n1_r     <= n1_nxt;
    n2_r     <= n1_r;
    q2_r     <= q2_nxt;
    r3_r     <= r3_nxt;
    q3_r     <= q2_r;
    c4_r     <= c4_nxt;
    q4_r     <= q3_r;
    quot4_r  <= quot4_nxt;
    status_r <= status_nxt;
    note_r   <= note_nxt;
    cents_r  <= cents_nxt;
    has_r    <= has_nxt;
    pc_r     <= pc_nxt;
    oct_r    <= oct_nxt;
  end

  assign ctl5_r              = '{valid: valid_r, status: status_t'(status_r)};
  assign out_valid           = ctl5_r.valid;
  assign out_status          = ctl5_r.status;
  assign out_nearest_note    = note_r;
  assign out_cents_offset    = cents_r;
  assign out_has_pitch_class = has_r;
  assign out_pitch_class     = pc_r;
  assign out_octave          = oct_r;

endmodule
